/* hdl/sse_pkg.sv */
// ----------------------------------------------------------------------------
// sse_pkg
// Shared types and constants of the search stack engine.
// ----------------------------------------------------------------------------
package sse_pkg;

	localparam int DEF_CAPACITY = 64;

	localparam logic [2:0] KIND_PUSH = 3'd0;
	localparam logic [2:0] KIND_POP = 3'd1;
	localparam logic [2:0] KIND_DELETE = 3'd2;
	localparam logic [2:0] KIND_COUNT = 3'd3;
	localparam logic [2:0] KIND_INDEX = 3'd4;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_ABSENT = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_SHIFT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic latch;
		logic decode;
		logic scan_start;
		logic shift_start;
		logic rd_en;
		logic shift_mode;
		logic dec;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic needs_scan;
		logic is_delete;
		logic found;
		logic rd_done;
		logic inflight;
	} stat_t;

endpackage

/* hdl/sse_ctrl.sv */
// ----------------------------------------------------------------------------
// sse_ctrl
// Sequencer of the search stack engine: steps each item through decode,
// scan, shift and result hand-off.
// ----------------------------------------------------------------------------
module sse_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  sse_pkg::stat_t stat,
	output sse_pkg::cmd_t  cmd
);

	sse_pkg::state_t state_q, state_n;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sse_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			sse_pkg::S_IDLE: begin
				if (in_valid) state_n = sse_pkg::S_DECODE;
			end
			sse_pkg::S_DECODE: begin
				state_n = stat.needs_scan ? sse_pkg::S_SCAN : sse_pkg::S_DONE;
			end
			sse_pkg::S_SCAN: begin
				if (stat.rd_done && !stat.inflight) begin
					state_n = (stat.is_delete && stat.found) ? sse_pkg::S_SHIFT
						: sse_pkg::S_DONE;
				end
			end
			sse_pkg::S_SHIFT: begin
				if (stat.rd_done && !stat.inflight) state_n = sse_pkg::S_DONE;
			end
			sse_pkg::S_DONE: begin
				if (!out_valid_q || out_ready) state_n = sse_pkg::S_IDLE;
			end
			default: state_n = sse_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			sse_pkg::S_IDLE: begin
				cmd.latch = in_valid;
			end
			sse_pkg::S_DECODE: begin
				cmd.decode = 1'b1;
				cmd.scan_start = stat.needs_scan;
			end
			sse_pkg::S_SCAN: begin
				cmd.rd_en = 1'b1;
				cmd.shift_start = stat.rd_done && !stat.inflight && stat.is_delete
					&& stat.found;
			end
			sse_pkg::S_SHIFT: begin
				cmd.rd_en = 1'b1;
				cmd.shift_mode = 1'b1;
				cmd.dec = stat.rd_done && !stat.inflight;
			end
			sse_pkg::S_DONE: begin
				cmd.load_out = !out_valid_q || out_ready;
			end
			default: cmd = '0;
		endcase
	end

	assign in_ready = (state_q == sse_pkg::S_IDLE);
	assign out_valid = out_valid_q;

	a_load_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result loaded over a result not yet taken");

	a_shift_needs_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sse_pkg::S_SHIFT) |-> stat.found)
		else $error("shift phase entered without a match");

	a_accept_decodes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == sse_pkg::S_DECODE))
		else $error("accepted item not decoded next cycle");

endmodule

/* hdl/sse_datapath.sv */
// ----------------------------------------------------------------------------
// sse_datapath
// Entry memory kept as a ring around a head pointer, scan pipeline with
// compare and match counter, gap-closing shift and the result register.
// ----------------------------------------------------------------------------
module sse_datapath #(
	parameter int CAPACITY = sse_pkg::DEF_CAPACITY
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sse_pkg::cmd_t      cmd,
	output sse_pkg::stat_t     stat,
	input  logic [2:0]         kind,
	input  logic [31:0]        value,
	output logic [1:0]         status,
	output logic [6:0]         match_count,
	output logic [6:0]         first_index,
	output logic [6:0]         length
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	logic [31:0] mem [CAPACITY];

	logic [2:0]    kind_q;
	logic [31:0]   key_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] rd_pos_q;
	logic [CW-1:0] pos_s1;
	logic          rdv_s1;
	logic [31:0]   rdata_s1;
	logic [CW-1:0] mcnt_q;
	logic          found_q;
	logic [CW-1:0] first_q;
	logic [1:0]    st_q;

	logic [1:0] status_q;
	logic [6:0] match_count_q;
	logic [6:0] first_index_q;
	logic [6:0] length_q;

	logic          full, empty, rd_done, push_ok, pop_ok, we, hit;
	logic [AW-1:0] head_dec, head_inc, raddr, waddr;
	logic [31:0]   wdata;
	logic [CW-1:0] wpos;
	logic [31:0]   mcnt_ext, first_ext, count_ext;
	logic [1:0]    status_n;

	function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
		input logic [AW-1:0] pos);
		logic [AW:0] sum;
		sum = {1'b0, head} + {1'b0, pos};
		if (sum >= (AW+1)'(CAPACITY)) sum = sum - (AW+1)'(CAPACITY);
		return sum[AW-1:0];
	endfunction

	assign full = (count_q == CW'(CAPACITY));
	assign empty = (count_q == '0);
	assign rd_done = (rd_pos_q >= count_q);
	assign push_ok = cmd.decode && (kind_q == sse_pkg::KIND_PUSH) && !full;
	assign pop_ok = cmd.decode && (kind_q == sse_pkg::KIND_POP) && !empty;
	assign head_dec = (head_q == '0) ? AW'(CAPACITY - 1) : head_q - AW'(1);
	assign head_inc = (head_q == AW'(CAPACITY - 1)) ? '0 : head_q + AW'(1);
	assign raddr = phys(head_q, rd_pos_q[AW-1:0]);
	assign wpos = pos_s1 - CW'(1);
	assign waddr = push_ok ? head_dec : phys(head_q, wpos[AW-1:0]);
	assign wdata = push_ok ? key_q : rdata_s1;
	assign we = push_ok || (rdv_s1 && cmd.shift_mode);
	assign hit = rdv_s1 && !cmd.shift_mode && (rdata_s1 == key_q);

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_s1 <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			count_q <= '0;
			rdv_s1 <= 1'b0;
		end else begin
			rdv_s1 <= cmd.rd_en && !rd_done;
			if (push_ok) begin
				head_q <= head_dec;
				count_q <= count_q + CW'(1);
			end else if (pop_ok) begin
				head_q <= head_inc;
				count_q <= count_q - CW'(1);
			end else if (cmd.dec) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			kind_q <= kind;
			key_q <= value;
		end
		pos_s1 <= rd_pos_q;
		if (cmd.scan_start) begin
			rd_pos_q <= '0;
		end else if (cmd.shift_start) begin
			rd_pos_q <= first_q + CW'(1);
		end else if (cmd.rd_en && !rd_done) begin
			rd_pos_q <= rd_pos_q + CW'(1);
		end
		if (cmd.scan_start) begin
			mcnt_q <= '0;
			found_q <= 1'b0;
			first_q <= '0;
		end else if (hit) begin
			mcnt_q <= mcnt_q + CW'(1);
			if (!found_q) begin
				found_q <= 1'b1;
				first_q <= pos_s1;
			end
		end
		if (cmd.decode) begin
			if (kind_q == sse_pkg::KIND_PUSH && full) begin
				st_q <= sse_pkg::ST_FULL;
			end else if (kind_q == sse_pkg::KIND_POP && empty) begin
				st_q <= sse_pkg::ST_EMPTY;
			end else begin
				st_q <= sse_pkg::ST_OK;
			end
		end
		if (cmd.load_out) begin
			status_q <= status_n;
			match_count_q <= (kind_q == sse_pkg::KIND_COUNT) ? mcnt_ext[6:0] : 7'd0;
			if (kind_q == sse_pkg::KIND_INDEX) begin
				first_index_q <= found_q ? first_ext[6:0] : 7'h7F;
			end else begin
				first_index_q <= 7'd0;
			end
			length_q <= count_ext[6:0];
		end
	end

	assign mcnt_ext = 32'(mcnt_q);
	assign first_ext = 32'(first_q);
	assign count_ext = 32'(count_q);

	always_comb begin
		case (kind_q) inside
			sse_pkg::KIND_PUSH, sse_pkg::KIND_POP: status_n = st_q;
			sse_pkg::KIND_DELETE, sse_pkg::KIND_INDEX:
				status_n = found_q ? sse_pkg::ST_OK : sse_pkg::ST_ABSENT;
			default: status_n = sse_pkg::ST_OK;
		endcase
	end

	assign stat.needs_scan = (kind_q == sse_pkg::KIND_DELETE)
		|| (kind_q == sse_pkg::KIND_COUNT) || (kind_q == sse_pkg::KIND_INDEX);
	assign stat.is_delete = (kind_q == sse_pkg::KIND_DELETE);
	assign stat.found = found_q;
	assign stat.rd_done = rd_done;
	assign stat.inflight = rdv_s1;

	assign status = status_q;
	assign match_count = match_count_q;
	assign first_index = first_index_q;
	assign length = length_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_shift_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(rdv_s1 && cmd.shift_mode) |-> (pos_s1 != '0 && found_q))
		else $error("shift write below the front");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		push_ok |=> (count_q == $past(count_q) + CW'(1)))
		else $error("push did not grow the list");

endmodule

/* hdl/search_stack_engine.sv */
// ----------------------------------------------------------------------------
// search_stack_engine
// Bounded ordered list of signed 32-bit values with push, pop, delete, count
// and index requests.
// ----------------------------------------------------------------------------
// One item is taken at a time and gives one result. Push, pop and unused
// kinds pass from decode straight to the result hand-off. Delete, count and
// index scan every held entry through the single read port of the entry
// memory, one entry per cycle; a delete that finds its value then closes
// the gap by copying each later entry forward, one per cycle. A new item is
// taken while the last result still waits at the output register.
module search_stack_engine #(
	parameter int CAPACITY = sse_pkg::DEF_CAPACITY
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         kind,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [6:0]         match_count,
	output logic signed [6:0]  first_index,
	output logic [6:0]         length
);

	sse_pkg::cmd_t  cmd;
	sse_pkg::stat_t stat;
	logic [6:0]     first_index_u;

	sse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	sse_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.kind        (kind),
		.value       (value),
		.status      (status),
		.match_count (match_count),
		.first_index (first_index_u),
		.length      (length)
	);

	assign first_index = first_index_u;

endmodule

/* tb/search_stack_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// search_stack_checker
// Watches both channels of the search stack engine, keeps its own copy of the
// list, predicts the result of every accepted request and compares each
// returned result with the oldest prediction still outstanding.
// ----------------------------------------------------------------------------
module search_stack_checker #(
	parameter int CAPACITY = sse_pkg::DEF_CAPACITY
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [2:0]         kind,
	input  logic signed [31:0] value,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [1:0]         status,
	input  logic [6:0]         match_count,
	input  logic signed [6:0]  first_index,
	input  logic [6:0]         length,
	output int                 mismatches,
	output int                 waiting
);

	typedef struct packed {
		logic [1:0]        status;
		logic [6:0]        match_count;
		logic signed [6:0] first_index;
		logic [6:0]        length;
	} list_result_t;

	logic signed [31:0] held_values[$];
	list_result_t       expected_results[$];
	list_result_t       got;
	list_result_t       want;
	int                 fail_total;
	int                 result_no;

	function automatic list_result_t apply_request(input logic [2:0] k,
			input logic signed [31:0] v);
		list_result_t r;
		int first_pos;
		int hits;
		r = '0;
		r.status = sse_pkg::ST_OK;
		first_pos = -1;
		hits = 0;
		for (int i = 0; i < held_values.size(); i++) begin
			if (held_values[i] == v) begin
				hits++;
				if (first_pos < 0)
					first_pos = i;
			end
		end
		case (k)
			sse_pkg::KIND_PUSH: begin
				if (held_values.size() >= CAPACITY)
					r.status = sse_pkg::ST_FULL;
				else
					held_values.push_front(v);
			end
			sse_pkg::KIND_POP: begin
				if (held_values.size() == 0)
					r.status = sse_pkg::ST_EMPTY;
				else
					void'(held_values.pop_front());
			end
			sse_pkg::KIND_DELETE: begin
				if (first_pos < 0)
					r.status = sse_pkg::ST_ABSENT;
				else
					held_values.delete(first_pos);
			end
			sse_pkg::KIND_COUNT: begin
				r.match_count = 7'(hits);
			end
			sse_pkg::KIND_INDEX: begin
				if (first_pos < 0) begin
					r.status = sse_pkg::ST_ABSENT;
					r.first_index = '1;
				end else begin
					r.first_index = 7'(first_pos);
				end
			end
			default: begin
			end
		endcase
		r.length = 7'(held_values.size());
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_values.delete();
			expected_results.delete();
			fail_total = 0;
			result_no = 0;
			mismatches <= 0;
			waiting <= 0;
		end else begin
			// The result side is handled first so that a request taken at the
			// same edge can never be matched against this result.
			if (out_valid && out_ready) begin
				got = {status, match_count, first_index, length};
				result_no++;
				if (expected_results.size() == 0) begin
					fail_total++;
					if (fail_total <= 10)
						$display("%0t: result %0d arrived with no request outstanding",
							$realtime, result_no);
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						fail_total++;
						// Fields are status/match_count/first_index/length.
						if (fail_total <= 10)
							$display("%0t: result %0d expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
								$realtime, result_no,
								want.status, want.match_count, want.first_index,
								want.length, got.status, got.match_count,
								got.first_index, got.length);
					end
				end
			end
			if (in_valid && in_ready)
				expected_results.push_back(apply_request(kind, value));
			mismatches <= fail_total;
			waiting <= expected_results.size();
		end
	end

endmodule

/* tb/tb_search_stack_engine.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_search_stack_engine
// Drives directed and then random request sequences into the search stack
// engine with bursty input and a stalling output, and reports the verdict
// from the checker's mismatch and waiting counts.
// ----------------------------------------------------------------------------
module tb_search_stack_engine;

	localparam int CAPACITY = sse_pkg::DEF_CAPACITY;
	localparam int RANDOM_ITEMS = 1900;
	localparam int CYCLE_LIMIT = 1500000;

	typedef enum int {
		MIX_GROW,
		MIX_SHRINK,
		MIX_BALANCED
	} mix_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [2:0]         kind = sse_pkg::KIND_PUSH;
	logic signed [31:0] value = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [1:0]         status;
	logic [6:0]         match_count;
	logic signed [6:0]  first_index;
	logic [6:0]         length;
	int                 mismatches;
	int                 waiting;
	int                 cycles = 0;
	logic signed [31:0] value_pool[8];

	search_stack_engine #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.match_count(match_count),
		.first_index(first_index),
		.length(length)
	);

	search_stack_checker #(
		.CAPACITY(CAPACITY)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.match_count(match_count),
		.first_index(first_index),
		.length(length),
		.mismatches(mismatches),
		.waiting(waiting)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic send_item(input logic [2:0] k, input logic signed [31:0] v);
		in_valid <= 1'b1;
		kind <= k;
		value <= v;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic pause_sender(input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic signed [31:0] pick_value(input int pool_pct);
		if ($urandom_range(99) < pool_pct)
			return value_pool[3'($urandom_range(7))];
		return $urandom;
	endfunction

	function automatic logic [2:0] pick_kind(input mix_t mix);
		int roll;
		int push_lim;
		int pop_lim;
		int del_lim;
		roll = $urandom_range(99);
		case (mix)
			MIX_GROW: begin
				push_lim = 70;
				pop_lim = 78;
				del_lim = 86;
			end
			MIX_SHRINK: begin
				push_lim = 15;
				pop_lim = 45;
				del_lim = 75;
			end
			default: begin
				push_lim = 35;
				pop_lim = 50;
				del_lim = 65;
			end
		endcase
		if (roll < push_lim)
			return sse_pkg::KIND_PUSH;
		if (roll < pop_lim)
			return sse_pkg::KIND_POP;
		if (roll < del_lim)
			return sse_pkg::KIND_DELETE;
		if (roll < del_lim + 12)
			return sse_pkg::KIND_COUNT;
		if (roll < 97)
			return sse_pkg::KIND_INDEX;
		return sse_pkg::KIND_INDEX + 3'($urandom_range(1, 3));
	endfunction

	task automatic run_directed();
		send_item(sse_pkg::KIND_POP, 32'sd0);
		send_item(sse_pkg::KIND_DELETE, 32'sd5);
		send_item(sse_pkg::KIND_INDEX, 32'sd5);
		send_item(sse_pkg::KIND_COUNT, 32'sd5);
		send_item(sse_pkg::KIND_PUSH, 32'sh8000_0000);
		send_item(sse_pkg::KIND_PUSH, 32'sh7FFF_FFFF);
		send_item(sse_pkg::KIND_PUSH, 32'sd0);
		send_item(sse_pkg::KIND_PUSH, -32'sd1);
		send_item(sse_pkg::KIND_PUSH, 32'sh7FFF_FFFF);
		pause_sender(3);
		send_item(sse_pkg::KIND_COUNT, 32'sh7FFF_FFFF);
		send_item(sse_pkg::KIND_INDEX, 32'sh7FFF_FFFF);
		send_item(sse_pkg::KIND_INDEX, 32'sh8000_0000);
		send_item(sse_pkg::KIND_DELETE, 32'sh7FFF_FFFF);
		send_item(sse_pkg::KIND_DELETE, 32'sh8000_0000);
		send_item(sse_pkg::KIND_DELETE, 32'sd12345);
		send_item(sse_pkg::KIND_COUNT, 32'sd7);
		send_item(sse_pkg::KIND_INDEX + 3'd1, $urandom);
		send_item(sse_pkg::KIND_INDEX + 3'd2, $urandom);
		send_item(sse_pkg::KIND_INDEX + 3'd3, $urandom);
		send_item(sse_pkg::KIND_POP, $urandom);
		send_item(sse_pkg::KIND_INDEX, 32'sh5555_5555);
		send_item(sse_pkg::KIND_PUSH, 32'shAAAA_AAAA);
		send_item(sse_pkg::KIND_PUSH, 32'sh5555_5555);
	endtask

	task automatic run_random();
		int sent;
		int seg_left;
		int burst_left;
		mix_t mix;
		logic [2:0] k;
		sent = 0;
		seg_left = 0;
		burst_left = 0;
		mix = MIX_BALANCED;
		while (sent < RANDOM_ITEMS) begin
			if (seg_left == 0) begin
				mix = mix_t'($urandom_range(2));
				seg_left = $urandom_range(20, 120);
			end
			if (burst_left == 0) begin
				if ($urandom_range(3) != 0)
					pause_sender($urandom_range(1, 20));
				burst_left = ($urandom_range(4) == 0) ? $urandom_range(50, 150)
					: $urandom_range(1, 30);
			end
			k = pick_kind(mix);
			send_item(k, pick_value((k == sse_pkg::KIND_PUSH) ? 70 : 80));
			sent++;
			seg_left--;
			burst_left--;
		end
	endtask

	// Output side: stall patterns change per segment, and one long hold-off
	// lets the block back up until it refuses new requests.
	initial begin
		int seg;
		int span;
		int ready_pct;
		@(posedge arst_n);
		seg = 0;
		forever begin
			seg++;
			if (seg == 10) begin
				out_ready <= 1'b0;
				repeat (500) @(posedge clk);
			end
			span = $urandom_range(20, 200);
			case ($urandom_range(3))
				0: ready_pct = 100;
				1: ready_pct = 50;
				2: ready_pct = 25;
				default: ready_pct = 85;
			endcase
			repeat (span) begin
				out_ready <= ($urandom_range(99) < ready_pct);
				@(posedge clk);
			end
		end
	end

	initial begin
		value_pool[0] = 32'sh8000_0000;
		value_pool[1] = 32'sh7FFF_FFFF;
		value_pool[2] = 32'sd0;
		value_pool[3] = -32'sd1;
		value_pool[4] = 32'sd1;
		value_pool[5] = $urandom;
		value_pool[6] = $urandom;
		value_pool[7] = $urandom;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random();
		in_valid <= 1'b0;
		while (waiting != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && waiting == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
